FILE: design/stt_pkg.sv
// Package for the timer slot table: sizes, action and status codes, sequencer states.
// No dependencies; used by every module of the block.
package stt_pkg;

	localparam int SLOTS     = 16;
	localparam int TICK_BITS = 32;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);

	localparam logic [2:0] ACT_SET_ONESHOT   = 3'd0;
	localparam logic [2:0] ACT_SET_PERIODIC  = 3'd1;
	localparam logic [2:0] ACT_CLR_ONESHOT   = 3'd2;
	localparam logic [2:0] ACT_CLR_PERIODIC  = 3'd3;
	localparam logic [2:0] ACT_TICK          = 3'd4;

	typedef enum logic [2:0] {
		STAT_SET_OK = 3'd0,
		STAT_FULL   = 3'd1,
		STAT_CLEAR  = 3'd2,
		STAT_FIRED  = 3'd3,
		STAT_DONE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_CLEAR,
		ST_TICK,
		ST_DONE
	} state_t;

	typedef logic [TICK_BITS-1:0] tick_t;

endpackage

FILE: design/software_timer_slot_table.sv
// Timer slot table top level: sequencer, slot storage and result register.
// Depends on stt_pkg and stt_fire_chk. The shared compare examines one slot per cycle.
// A set scans for the lowest free slot; a clear by id frees that slot; a clear all scans every
// slot; a tick reports each firing slot as it is examined, then a done result.
// A new transfer is accepted only when the sequencer is idle (busy low).
// No stalls; reset frees all slots.
module software_timer_slot_table import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [31:0] now,
	input  logic [31:0] wait_req,
	input  logic        clear_all,
	input  logic [3:0]  slot_id,
	output logic        valid,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [4:0]  freed_count,
	output logic        last
);

	state_t state_q, state_d;

	logic [2:0]        action_q;
	tick_t             now_q;
	tick_t             wait_q;
	logic              all_q;
	logic [3:0]        id_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [SLOTS-1:0]  slot_active_q;
	logic [SLOTS-1:0]  slot_periodic_q;
	tick_t             slot_start_q [SLOTS];
	tick_t             slot_wait_q  [SLOTS];

	logic              accept;
	logic              idx_last;
	logic              kind;
	logic [SLOT_W-1:0] id_idx;
	logic              id_ok;
	logic              fire;

	// table update controls
	logic              claim;
	logic              free_en;
	logic              restart;
	logic [SLOT_W-1:0] upd_idx;
	logic              cnt_inc;

	// result controls
	logic              res_valid;
	status_t           res_status;
	logic [3:0]        res_slot;
	logic [4:0]        res_cnt;
	logic              res_last;

	logic              valid_q;
	status_t           status_q;
	logic [3:0]        slot_q;
	logic [4:0]        freed_q;
	logic              last_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign idx_last = (idx_q == SLOT_W'(SLOTS - 1));
	assign kind     = (action_q == ACT_CLR_PERIODIC);
	assign id_idx   = SLOT_W'(id_q);
	assign id_ok    = (32'(id_q) < SLOTS);

	stt_fire_chk u_fire (
		.now        (now_q),
		.start_tick (slot_start_q[idx_q]),
		.wait_ticks (slot_wait_q[idx_q]),
		.fire       (fire)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (action == ACT_SET_ONESHOT || action == ACT_SET_PERIODIC)
						state_d = ST_SET;
					else if (action == ACT_CLR_ONESHOT || action == ACT_CLR_PERIODIC)
						state_d = ST_CLEAR;
					else if (action == ACT_TICK)
						state_d = ST_TICK;
					else
						state_d = ST_IDLE;
				end
			end
			ST_SET: begin
				if (!slot_active_q[idx_q] || idx_last)
					state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (!all_q || idx_last)
					state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (idx_last)
					state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and table controls
	always_comb begin
		claim      = 1'b0;
		free_en    = 1'b0;
		restart    = 1'b0;
		upd_idx    = idx_q;
		cnt_inc    = 1'b0;
		res_valid  = 1'b0;
		res_status = STAT_SET_OK;
		res_slot   = '0;
		res_cnt    = '0;
		res_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_SET: begin
				if (!slot_active_q[idx_q]) begin
					claim      = 1'b1;
					res_valid  = 1'b1;
					res_status = STAT_SET_OK;
					res_slot   = 4'(idx_q);
					res_last   = 1'b1;
				end else if (idx_last) begin
					res_valid  = 1'b1;
					res_status = STAT_FULL;
					res_last   = 1'b1;
				end
			end
			ST_CLEAR: begin
				if (all_q) begin
					if (slot_active_q[idx_q] && slot_periodic_q[idx_q] == kind) begin
						free_en = 1'b1;
						cnt_inc = 1'b1;
					end
					if (idx_last) begin
						res_valid  = 1'b1;
						res_status = STAT_CLEAR;
						res_cnt    = 5'(cnt_q) + 5'(cnt_inc);
						res_last   = 1'b1;
					end
				end else begin
					upd_idx    = id_idx;
					free_en    = id_ok && slot_active_q[id_idx];
					res_valid  = 1'b1;
					res_status = STAT_CLEAR;
					res_cnt    = 5'(free_en);
					res_last   = 1'b1;
				end
			end
			ST_TICK: begin
				if (slot_active_q[idx_q] && fire) begin
					res_valid  = 1'b1;
					res_status = STAT_FIRED;
					res_slot   = 4'(idx_q);
					if (slot_periodic_q[idx_q])
						restart = 1'b1;
					else
						free_en = 1'b1;
				end
			end
			ST_DONE: begin
				res_valid  = 1'b1;
				res_status = STAT_DONE;
				res_last   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= res_valid;
			if (accept) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (busy) begin
				idx_q <= idx_q + SLOT_W'(1);
				cnt_q <= cnt_q + CNT_W'(cnt_inc);
			end
		end
	end

	// captured transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			now_q    <= TICK_BITS'(now);
			wait_q   <= TICK_BITS'(wait_req);
			all_q    <= clear_all;
			id_q     <= slot_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_active_q   <= '0;
			slot_periodic_q <= '0;
		end else begin
			if (claim) begin
				slot_active_q[upd_idx]   <= 1'b1;
				slot_periodic_q[upd_idx] <= (action_q == ACT_SET_PERIODIC);
			end else if (free_en) begin
				slot_active_q[upd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			slot_start_q[upd_idx] <= now_q;
			slot_wait_q[upd_idx]  <= wait_q;
		end else if (restart) begin
			slot_start_q[upd_idx] <= now_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			freed_q  <= res_cnt;
			last_q   <= res_last;
		end
	end

	assign valid       = valid_q;
	assign status      = status_q;
	assign slot_out    = slot_q;
	assign freed_count = freed_q;
	assign last        = last_q;

endmodule

FILE: design/stt_fire_chk.sv
// Expiry compare shared by all slots: elapsed = (now - start) mod 2^TICK_BITS >= wait.
// Depends on stt_pkg.
module stt_fire_chk import stt_pkg::*; (
	input  tick_t now,
	input  tick_t start_tick,
	input  tick_t wait_ticks,
	output logic  fire
);

	tick_t elapsed;

	assign elapsed = now - start_tick;
	assign fire    = (elapsed >= wait_ticks);

endmodule

FILE: tb/software_timer_slot_table_tb.sv
// Self-checking bench for the timer slot table: a directed sequence, then random set, clear,
// tick and unused actions, all checked against a predictor of the slot state.
// Depends on stt_pkg and software_timer_slot_table.
module software_timer_slot_table_tb;
	import stt_pkg::*;

	localparam logic [2:0] ACT_LAST_CODE = 3'd7;
	localparam tick_t      TICK_MAX      = '1;

	typedef struct {
		logic [2:0]        action;
		tick_t             now;
		tick_t             wait_req;
		logic              clear_all;
		logic [SLOT_W-1:0] slot_id;
	} timer_cmd_t;

	typedef struct {
		status_t           st;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  cnt;
		logic              lst;
	} timer_report_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic [2:0]        action      = '0;
	logic [31:0]       now         = '0;
	logic [31:0]       wait_req    = '0;
	logic              clear_all   = 1'b0;
	logic [3:0]        slot_id     = '0;
	logic              busy;
	logic              valid;
	logic [2:0]        status;
	logic [3:0]        slot_out;
	logic [4:0]        freed_count;
	logic              last;

	// predicted slot state
	logic              m_active   [SLOTS];
	logic              m_periodic [SLOTS];
	tick_t             m_start    [SLOTS];
	tick_t             m_wait     [SLOTS];

	timer_cmd_t        cmd_q[$];
	timer_report_t     timer_reports_q[$];
	timer_cmd_t        cur_cmd;
	logic              holding    = 1'b0;
	logic              took       = 1'b0;
	int                burst_left = 1;
	int                gap_left   = 0;
	int                mismatches = 0;

	software_timer_slot_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.now         (now),
		.wait_req    (wait_req),
		.clear_all   (clear_all),
		.slot_id     (slot_id),
		.valid       (valid),
		.status      (status),
		.slot_out    (slot_out),
		.freed_count (freed_count),
		.last        (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void queue_report(input status_t st, input logic [SLOT_W-1:0] slot,
			input logic [CNT_W-1:0] cnt, input logic lst);
		timer_report_t r;
		r.st   = st;
		r.slot = slot;
		r.cnt  = cnt;
		r.lst  = lst;
		timer_reports_q.push_back(r);
	endfunction

	// Updates the slot state for one accepted command and queues the reports it causes.
	function automatic void apply_timer_action(input timer_cmd_t c);
		int    found;
		int    freed;
		logic  kind;
		tick_t elapsed;
		case (c.action)
			ACT_SET_ONESHOT, ACT_SET_PERIODIC: begin
				found = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!m_active[i] && found < 0)
						found = i;
				if (found >= 0) begin
					m_active[found]   = 1'b1;
					m_periodic[found] = (c.action == ACT_SET_PERIODIC);
					m_start[found]    = c.now;
					m_wait[found]     = c.wait_req;
					queue_report(STAT_SET_OK, SLOT_W'(found), '0, 1'b1);
				end else
					queue_report(STAT_FULL, '0, '0, 1'b1);
			end
			ACT_CLR_ONESHOT, ACT_CLR_PERIODIC: begin
				kind  = (c.action == ACT_CLR_PERIODIC);
				freed = 0;
				if (c.clear_all) begin
					for (int i = 0; i < SLOTS; i++)
						if (m_active[i] && m_periodic[i] == kind) begin
							m_active[i] = 1'b0;
							freed++;
						end
				end else if (int'(c.slot_id) < SLOTS && m_active[c.slot_id]) begin
					m_active[c.slot_id] = 1'b0;
					freed = 1;
				end
				queue_report(STAT_CLEAR, '0, CNT_W'(freed), 1'b1);
			end
			ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					elapsed = c.now - m_start[i];
					if (m_active[i] && elapsed >= m_wait[i]) begin
						queue_report(STAT_FIRED, SLOT_W'(i), '0, 1'b0);
						if (m_periodic[i])
							m_start[i] = c.now;
						else
							m_active[i] = 1'b0;
					end
				end
				queue_report(STAT_DONE, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic add_cmd(input logic [2:0] act, input tick_t t, input tick_t w,
			input logic all, input logic [SLOT_W-1:0] id);
		timer_cmd_t c;
		c.action    = act;
		c.now       = t;
		c.wait_req  = w;
		c.clear_all = all;
		c.slot_id   = id;
		cmd_q.push_back(c);
	endtask

	// Acceptance and result checking, sampled at the rising edge.
	always @(posedge clk) begin
		timer_report_t exp_r;
		if (arst_n) begin
			if (valid) begin
				if (timer_reports_q.size() == 0)
					flag_mismatch($sformatf("unexpected result status=%0d slot=%0d count=%0d last=%0b",
						status, slot_out, freed_count, last));
				else begin
					exp_r = timer_reports_q.pop_front();
					if (status !== exp_r.st)
						flag_mismatch($sformatf("status %0d, expected %s", status, exp_r.st.name()));
					if (slot_out !== exp_r.slot)
						flag_mismatch($sformatf("slot_out %0d, expected %0d", slot_out, exp_r.slot));
					if (freed_count !== exp_r.cnt)
						flag_mismatch($sformatf("freed_count %0d, expected %0d",
							freed_count, exp_r.cnt));
					if (last !== exp_r.lst)
						flag_mismatch($sformatf("last %0b, expected %0b", last, exp_r.lst));
				end
			end
			if (start && !busy) begin
				apply_timer_action(cur_cmd);
				took = 1'b1;
			end
		end
	end

	// Command driver: bursts of transfers separated by random gaps, driven on the falling edge.
	always @(negedge clk) begin
		logic go;
		if (arst_n) begin
			if (took) begin
				took    = 1'b0;
				holding = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
				end
			end
			go = 1'b0;
			if (holding)
				go = 1'b1;
			else if (gap_left > 0)
				gap_left--;
			else if (cmd_q.size() > 0) begin
				cur_cmd = cmd_q.pop_front();
				holding = 1'b1;
				go      = 1'b1;
			end
			start     <= go;
			action    <= cur_cmd.action;
			now       <= cur_cmd.now;
			wait_req  <= cur_cmd.wait_req;
			clear_all <= cur_cmd.clear_all;
			slot_id   <= cur_cmd.slot_id;
		end
	end

	initial begin
		tick_t gen_now;
		int    roll;
		int    fill_mode;
		tick_t w;

		for (int i = 0; i < SLOTS; i++) begin
			m_active[i]   = 1'b0;
			m_periodic[i] = 1'b0;
			m_start[i]    = '0;
			m_wait[i]     = '0;
		end
		cur_cmd = '{ACT_TICK, '0, '0, 1'b0, '0};

		// directed: empty table, unused codes, full table across the wrap, max fires, clears
		add_cmd(ACT_TICK, '0, '0, 1'b0, '0);
		add_cmd(ACT_CLR_ONESHOT, '0, '0, 1'b0, SLOT_W'(SLOTS - 1));
		for (int a = ACT_TICK + 1; a <= ACT_LAST_CODE; a++)
			add_cmd(3'(a), TICK_MAX, TICK_MAX, 1'b1, '1);
		for (int i = 0; i < SLOTS; i++)
			add_cmd((i % 2) ? ACT_SET_PERIODIC : ACT_SET_ONESHOT, 32'hFFFF_FFF0,
				(i == 1) ? 32'h20 : 32'h0, 1'b0, '0);
		add_cmd(ACT_SET_PERIODIC, 32'hFFFF_FFF0, '0, 1'b0, '0);
		// elapsed wraps to exactly the wait of slot 1, so every slot fires
		add_cmd(ACT_TICK, 32'h10, '0, 1'b0, '0);
		add_cmd(ACT_CLR_PERIODIC, '0, '0, 1'b0, SLOT_W'(3));
		add_cmd(ACT_CLR_ONESHOT, '0, '0, 1'b0, SLOT_W'(5));
		add_cmd(ACT_SET_PERIODIC, 32'h10, TICK_MAX, 1'b0, '0);
		add_cmd(ACT_SET_ONESHOT, 32'h10, 32'h5, 1'b0, '0);
		add_cmd(ACT_TICK, 32'h15, '0, 1'b0, '0);
		add_cmd(ACT_CLR_ONESHOT, '0, '0, 1'b1, '0);
		add_cmd(ACT_CLR_PERIODIC, '0, '0, 1'b1, '0);

		// random: filling or draining phases, the phase chosen at random every 40 commands
		gen_now   = $urandom;
		fill_mode = 1;
		for (int n = 0; n < 470; n++) begin
			if (n % 40 == 0)
				fill_mode = $urandom_range(0, 1);
			roll = $urandom_range(0, 99);
			if (roll < 8)
				gen_now = $urandom;
			else if (roll < 12)
				gen_now = TICK_MAX - $urandom_range(0, 30);
			else
				gen_now = gen_now + $urandom_range(0, 12);
			roll = $urandom_range(0, 99);
			if (roll < 12)
				w = '0;
			else if (roll < 22)
				w = $urandom;
			else if (roll < 26)
				w = TICK_MAX;
			else
				w = $urandom_range(1, 40);
			roll = $urandom_range(0, 99);
			if (roll < 5)
				add_cmd(3'($urandom_range(ACT_TICK + 1, ACT_LAST_CODE)), $urandom, $urandom,
					1'($urandom), SLOT_W'($urandom));
			else if (roll < (fill_mode ? 60 : 25))
				add_cmd($urandom_range(0, 1) ? ACT_SET_PERIODIC : ACT_SET_ONESHOT, gen_now, w,
					1'($urandom), SLOT_W'($urandom));
			else if (roll < (fill_mode ? 80 : 60))
				add_cmd(ACT_TICK, gen_now, $urandom, 1'($urandom), SLOT_W'($urandom));
			else
				add_cmd($urandom_range(0, 1) ? ACT_CLR_PERIODIC : ACT_CLR_ONESHOT, $urandom,
					$urandom, ($urandom_range(0, 3) == 0), SLOT_W'($urandom));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || holding)
			@(posedge clk);
		while (timer_reports_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
design/stt_pkg.sv
design/stt_fire_chk.sv
design/software_timer_slot_table.sv
tb/software_timer_slot_table_tb.sv
